/* rtl/csvdue_pkg.sv */
// shared types and constants for the due-row counter
`timescale 1ns / 1ps

package csvdue_pkg;

    // configuration register indexes
    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_SESSION   = 1'b1;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // number parse phases
    localparam logic [1:0] PH_BLANKS = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    // special bytes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    // running state of the schedule number
    typedef struct packed {
        logic [1:0]  phase;
        logic        negative;
        logic [31:0] value;
    } t_num;

endpackage

/* rtl/csvdue_in_if.sv */
// input channel: table bytes and end items
`timescale 1ns / 1ps

interface csvdue_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

/* rtl/csvdue_out_if.sv */
// output channel: counts reported at the end of a table
`timescale 1ns / 1ps

interface csvdue_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] answer_count;
    logic [31:0] due_count;
    logic [31:0] row_count;
    logic        schedule_present;

    modport source (output valid, output answer_count, output due_count,
                    output row_count, output schedule_present, input ready);
    modport sink   (input valid, input answer_count, input due_count,
                    input row_count, input schedule_present, output ready);
endinterface

/* rtl/csvdue_num.sv */
// one character step of the atol-style schedule number parse
`timescale 1ns / 1ps

module csvdue_num (
    input  csvdue_pkg::t_num i_cur,
    input  logic [7:0]       i_char,
    output csvdue_pkg::t_num o_next
);

    logic        w_blank;
    logic        w_digit;
    logic [31:0] w_digit_val;
    logic [31:0] w_times_ten;

    assign w_blank = (i_char == csvdue_pkg::CH_SPACE) || (i_char == csvdue_pkg::CH_TAB) ||
                     (i_char == csvdue_pkg::CH_LF) || (i_char == csvdue_pkg::CH_VT) ||
                     (i_char == csvdue_pkg::CH_FF) || (i_char == csvdue_pkg::CH_CR);
    assign w_digit = (i_char >= csvdue_pkg::CH_ZERO) && (i_char <= csvdue_pkg::CH_NINE);
    assign w_digit_val = {24'd0, i_char - csvdue_pkg::CH_ZERO};
    // x*10 as x*8 + x*2, wrapping
    assign w_times_ten = {i_cur.value[28:0], 3'd0} + {i_cur.value[30:0], 1'b0};

    always_comb begin
        o_next = i_cur;
        case (i_cur.phase)
            csvdue_pkg::PH_BLANKS: begin
                if (!w_blank) begin
                    if ((i_char == csvdue_pkg::CH_PLUS) || (i_char == csvdue_pkg::CH_MINUS)) begin
                        o_next.negative = (i_char == csvdue_pkg::CH_MINUS);
                        o_next.phase    = csvdue_pkg::PH_DIGITS;
                    end else if (w_digit) begin
                        o_next.value = w_digit_val;
                        o_next.phase = csvdue_pkg::PH_DIGITS;
                    end else begin
                        o_next.phase = csvdue_pkg::PH_STOP;
                    end
                end
            end
            csvdue_pkg::PH_DIGITS: begin
                if (w_digit) begin
                    o_next.value = w_times_ten + w_digit_val;
                end else begin
                    o_next.phase = csvdue_pkg::PH_STOP;
                end
            end
            default: begin
                o_next = i_cur;
            end
        endcase
    end

endmodule

/* rtl/csv_due_row_counter.sv */
// Due-row counter for a delimited text table.
// Bytes of the table arrive on i_in with opcode 0, one item per byte; an item
// with opcode 1 ends the table. Only the end item gives a result on o_out:
// the due count (or the row count when the header lacks schedule columns),
// both counts and the schedule flag. The state then clears for a new table.
// i_cfg_we/i_cfg_index/i_cfg_data write the field delimiter (index 0) and the
// current session (index 1); the user must do so only while the block is idle,
// which the block itself does not enforce. An item is taken into an input
// register and processed from there by a single pass of compares, a times-ten
// add and one 32-bit compare; an end item's counts are then registered in the
// output register. Throughput is one item per cycle but for a waiting end item.
// When o_out stalls, table bytes keep flowing; only a second end item waits
// in the input register until the held result is taken.
// Synchronous reset clears the parser state, empties both registers and
// loads delimiter 44 and session 0.
`timescale 1ns / 1ps

module csv_due_row_counter #(
    parameter int COLUMN_COUNT = 6,
    parameter int DIGIT_LIMIT  = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    csvdue_in_if.sink   i_in,
    csvdue_out_if.source o_out
);

    localparam logic [7:0] LAST_FIELD = 8'(COLUMN_COUNT - 1);
    localparam logic [3:0] CHAR_LIMIT = 4'(DIGIT_LIMIT);

    // configuration
    logic [7:0]  r_delim;
    logic [31:0] r_session;

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // parser state
    logic             r_in_quotes,   n_in_quotes;
    logic             r_after_close, n_after_close;
    logic [7:0]       r_field_idx,   n_field_idx;
    logic [3:0]       r_chars,       n_chars;
    csvdue_pkg::t_num r_num,         n_num;
    logic             r_row_data,    n_row_data;
    logic             r_hdr_pending, n_hdr_pending;
    logic             r_has_sched,   n_has_sched;
    logic [31:0]      r_due,         n_due;
    logic [31:0]      r_rows,        n_rows;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_answer;
    logic [31:0] r_out_due;
    logic [31:0] r_out_rows;
    logic        r_out_sched;

    logic             w_advance;
    logic             w_process;
    logic             w_load_out;
    csvdue_pkg::t_num w_num_next;
    logic [31:0]      w_signed_val;
    logic             w_due_hit;
    logic [31:0]      w_fin_rows;
    logic [31:0]      w_fin_due;
    logic [8:0]       w_hdr_fields;
    logic [31:0]      w_end_rows;
    logic [31:0]      w_end_due;

    // an end item needs the output slot free or draining
    assign w_advance  = !(r_in_op == csvdue_pkg::OP_END && r_out_valid && !o_out.ready);
    assign w_process  = r_in_valid && w_advance;
    assign w_load_out = w_process && (r_in_op == csvdue_pkg::OP_END);
    assign i_in.ready = !r_in_valid || w_advance;

    csvdue_num u_num (
        .i_cur  (r_num),
        .i_char (r_in_byte),
        .o_next (w_num_next)
    );

    // row close: row count and due test on the schedule field
    assign w_signed_val = r_num.negative ? (32'd0 - r_num.value) : r_num.value;
    assign w_due_hit    = r_has_sched && (r_field_idx == LAST_FIELD) && (r_chars != 4'd0) &&
                          (w_signed_val <= r_session);
    assign w_fin_rows   = (r_rows != 32'hFFFF_FFFF) ? r_rows + 32'd1 : r_rows;
    assign w_fin_due    = (w_due_hit && (r_due != 32'hFFFF_FFFF)) ? r_due + 32'd1 : r_due;
    assign w_hdr_fields = {1'b0, r_field_idx} + 9'd1;

    assign w_end_rows = (r_row_data && !r_hdr_pending) ? w_fin_rows : r_rows;
    assign w_end_due  = (r_row_data && !r_hdr_pending) ? w_fin_due  : r_due;

    always_comb begin
        n_in_quotes   = r_in_quotes;
        n_after_close = r_after_close;
        n_field_idx   = r_field_idx;
        n_chars       = r_chars;
        n_num         = r_num;
        n_row_data    = r_row_data;
        n_hdr_pending = r_hdr_pending;
        n_has_sched   = r_has_sched;
        n_due         = r_due;
        n_rows        = r_rows;
        if (w_process) begin
            if (r_in_op == csvdue_pkg::OP_END) begin
                n_in_quotes   = 1'b0;
                n_after_close = 1'b0;
                n_field_idx   = 8'd0;
                n_chars       = 4'd0;
                n_num         = '0;
                n_row_data    = 1'b0;
                n_hdr_pending = 1'b1;
                n_has_sched   = 1'b0;
                n_due         = 32'd0;
                n_rows        = 32'd0;
            end else begin
                n_after_close = 1'b0;
                if (r_after_close && r_in_byte == csvdue_pkg::CH_QUOTE) begin
                    // doubled quote goes back into quote mode
                    n_in_quotes = 1'b1;
                end else if (r_in_quotes) begin
                    if (r_in_byte == csvdue_pkg::CH_QUOTE) begin
                        n_in_quotes   = 1'b0;
                        n_after_close = 1'b1;
                    end
                end else if (r_in_byte == csvdue_pkg::CH_QUOTE && r_chars == 4'd0) begin
                    n_in_quotes = 1'b1;
                end else if (r_in_byte == csvdue_pkg::CH_CR) begin
                    n_in_quotes = r_in_quotes;
                end else if (r_in_byte == r_delim) begin
                    if (r_field_idx != 8'hFF) begin
                        n_field_idx = r_field_idx + 8'd1;
                    end
                    n_chars = 4'd0;
                    n_num   = '0;
                end else if (r_in_byte == csvdue_pkg::CH_LF) begin
                    if (r_row_data) begin
                        if (r_hdr_pending) begin
                            n_has_sched   = (w_hdr_fields >= 9'(COLUMN_COUNT));
                            n_hdr_pending = 1'b0;
                        end else begin
                            n_rows = w_fin_rows;
                            n_due  = w_fin_due;
                        end
                    end
                    n_field_idx = 8'd0;
                    n_chars     = 4'd0;
                    n_num       = '0;
                    n_row_data  = 1'b0;
                end else begin
                    n_row_data = 1'b1;
                    if (r_field_idx == LAST_FIELD && r_chars < CHAR_LIMIT) begin
                        n_chars = r_chars + 4'd1;
                        n_num   = w_num_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim       <= csvdue_pkg::DELIM_RESET;
            r_session     <= 32'd0;
            r_in_valid    <= 1'b0;
            r_in_quotes   <= 1'b0;
            r_after_close <= 1'b0;
            r_field_idx   <= 8'd0;
            r_chars       <= 4'd0;
            r_num         <= '0;
            r_row_data    <= 1'b0;
            r_hdr_pending <= 1'b1;
            r_has_sched   <= 1'b0;
            r_due         <= 32'd0;
            r_rows        <= 32'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    csvdue_pkg::REG_DELIMITER: r_delim   <= i_cfg_data[7:0];
                    csvdue_pkg::REG_SESSION:   r_session <= i_cfg_data;
                    default:                   r_delim   <= r_delim;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_in_quotes   <= n_in_quotes;
            r_after_close <= n_after_close;
            r_field_idx   <= n_field_idx;
            r_chars       <= n_chars;
            r_num         <= n_num;
            r_row_data    <= n_row_data;
            r_hdr_pending <= n_hdr_pending;
            r_has_sched   <= n_has_sched;
            r_due         <= n_due;
            r_rows        <= n_rows;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.opcode;
            r_in_byte <= i_in.data_byte;
        end
        if (w_load_out) begin
            r_out_answer <= r_has_sched ? w_end_due : w_end_rows;
            r_out_due    <= w_end_due;
            r_out_rows   <= w_end_rows;
            r_out_sched  <= r_has_sched;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.answer_count     = r_out_answer;
    assign o_out.due_count        = r_out_due;
    assign o_out.row_count        = r_out_rows;
    assign o_out.schedule_present = r_out_sched;

endmodule

/* dv/tb_csv_due_row_counter.sv */
// self-checking bench for the due-row counter: directed table, then random tables
`timescale 1ns / 1ps

module tb_csv_due_row_counter;

    localparam int COLS        = 6;
    localparam int DIGITS      = 15;
    localparam int NPH         = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int LONG_HOLD   = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_LEN     = 33;

    typedef struct packed {
        logic [31:0] answer;
        logic [31:0] due;
        logic [31:0] rows;
        logic        sched;
    } t_count_rec;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       typed;
        t_count_rec rec;
    } t_step_row;

    localparam t_count_rec NO_COUNTS = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    csvdue_in_if  in_ch ();
    csvdue_out_if out_ch ();

    csv_due_row_counter #(
        .COLUMN_COUNT(COLS),
        .DIGIT_LIMIT (DIGITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // counts expected at the output, oldest first
    t_count_rec expected_counts [$];

    int  items_sent;
    int  counts_checked;
    int  mismatches;
    int  idle_pct;
    int  hold_token;
    int  cycle_cnt;
    bit  quiet_tail;

    // parser copy kept by the bench
    logic [7:0]       delim_cfg;
    logic [31:0]      session_cfg;
    bit               quoted;
    bit               close_seen;
    bit               row_live;
    bit               hdr_pending;
    bit               sched;
    logic [7:0]       col_idx;
    logic [3:0]       sched_chars;
    csvdue_pkg::t_num num;
    logic [31:0]      due_cnt;
    logic [31:0]      row_cnt;

    logic [7:0]  delim_plan [NPH] = '{8'd44, 8'd44, csvdue_pkg::CH_TAB, 8'hFF, 8'h00,
                                      csvdue_pkg::CH_QUOTE, csvdue_pkg::CH_LF,
                                      csvdue_pkg::CH_CR, 8'd44, 8'd44};
    logic [31:0] session_plan [NPH] = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd7, 32'd3,
                                        32'd10, 32'd5, 32'd2, 32'd0, 32'd0};

    t_step_row dir_steps [DIR_LEN] = '{
        '{csvdue_pkg::OP_END,  8'h00,    1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}},
        '{csvdue_pkg::OP_BYTE, 8'hFF,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_LF,    1'b0, NO_COUNTS},
        // sign with no digits, then a quote taken as data in the last field
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, "-",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_QUOTE, 1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_CR,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_LF,    1'b0, NO_COUNTS},
        // a row of quotes only is no row
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_QUOTE, 1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_QUOTE, 1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_LF,    1'b0, NO_COUNTS},
        // too few fields
        '{csvdue_pkg::OP_BYTE, 8'h00,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_LF,    1'b0, NO_COUNTS},
        // schedule field left empty
        '{csvdue_pkg::OP_BYTE, 8'h00,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, ",",      1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_BYTE, csvdue_pkg::CH_LF,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_END,  8'hA5,    1'b1, '{32'd1, 32'd1, 32'd3, 1'b1}},
        // header never finished
        '{csvdue_pkg::OP_BYTE, 8'h00,    1'b0, NO_COUNTS},
        '{csvdue_pkg::OP_END,  8'h5A,    1'b1, '{32'd0, 32'd0, 32'd0, 1'b0}}
    };

    function void clear_parser();
        quoted      = 1'b0;
        close_seen  = 1'b0;
        col_idx     = '0;
        sched_chars = '0;
        num         = '0;
        row_live    = 1'b0;
        hdr_pending = 1'b1;
        sched       = 1'b0;
        due_cnt     = '0;
        row_cnt     = '0;
    endfunction

    function void close_data_row();
        logic [31:0] v;
        if (row_cnt != '1) row_cnt++;
        if (sched && col_idx == COLS - 1 && sched_chars != 0) begin
            v = num.negative ? (32'd0 - num.value) : num.value;
            if (v <= session_cfg && due_cnt != '1) due_cnt++;
        end
    endfunction

    // advances the parser copy by one item; returns 1 when it yields counts
    function automatic bit predict_item(input logic op, input logic [7:0] c,
                                        output t_count_rec r);
        bit blank;
        bit digit;
        r = '0;
        if (op == csvdue_pkg::OP_END) begin
            if (row_live && !hdr_pending) close_data_row();
            r.answer = sched ? due_cnt : row_cnt;
            r.due    = due_cnt;
            r.rows   = row_cnt;
            r.sched  = sched;
            clear_parser();
            return 1'b1;
        end
        if (close_seen) begin
            close_seen = 1'b0;
            if (c == csvdue_pkg::CH_QUOTE) begin
                quoted = 1'b1;
                return 1'b0;
            end
        end
        if (quoted) begin
            if (c == csvdue_pkg::CH_QUOTE) begin
                quoted     = 1'b0;
                close_seen = 1'b1;
            end
            return 1'b0;
        end
        if (c == csvdue_pkg::CH_QUOTE && sched_chars == 0) begin
            quoted = 1'b1;
            return 1'b0;
        end
        if (c == csvdue_pkg::CH_CR) return 1'b0;
        if (c == delim_cfg) begin
            if (col_idx != 8'hFF) col_idx++;
            sched_chars = '0;
            num         = '0;
            return 1'b0;
        end
        if (c == csvdue_pkg::CH_LF) begin
            if (row_live) begin
                if (hdr_pending) begin
                    sched       = (int'(col_idx) + 1) >= COLS;
                    hdr_pending = 1'b0;
                end else begin
                    close_data_row();
                end
            end
            col_idx     = '0;
            sched_chars = '0;
            num         = '0;
            row_live    = 1'b0;
            return 1'b0;
        end
        row_live = 1'b1;
        if (col_idx == COLS - 1 && sched_chars < DIGITS) begin
            sched_chars++;
            digit = (c >= csvdue_pkg::CH_ZERO && c <= csvdue_pkg::CH_NINE);
            blank = (c == csvdue_pkg::CH_SPACE || c == csvdue_pkg::CH_TAB ||
                     c == csvdue_pkg::CH_LF || c == csvdue_pkg::CH_VT ||
                     c == csvdue_pkg::CH_FF || c == csvdue_pkg::CH_CR);
            case (num.phase)
                csvdue_pkg::PH_BLANKS: begin
                    if (!blank) begin
                        if (c == csvdue_pkg::CH_PLUS || c == csvdue_pkg::CH_MINUS) begin
                            num.negative = (c == csvdue_pkg::CH_MINUS);
                            num.phase    = csvdue_pkg::PH_DIGITS;
                        end else if (digit) begin
                            num.value = 32'(c - csvdue_pkg::CH_ZERO);
                            num.phase = csvdue_pkg::PH_DIGITS;
                        end else begin
                            num.phase = csvdue_pkg::PH_STOP;
                        end
                    end
                end
                csvdue_pkg::PH_DIGITS: begin
                    if (digit) num.value = num.value * 32'd10 + 32'(c - csvdue_pkg::CH_ZERO);
                    else num.phase = csvdue_pkg::PH_STOP;
                end
                default: ;
            endcase
        end
        return 1'b0;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] c,
                             input bit typed = 1'b0, input t_count_rec typed_rec = '0);
        t_count_rec r;
        bit         got;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.data_byte <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        got = predict_item(op, c, r);
        if (got) expected_counts = {expected_counts, (typed ? typed_rec : r)};
    endtask

    task automatic put(input logic [7:0] b);
        send_item(csvdue_pkg::OP_BYTE, b);
    endtask

    task automatic put_text(input string s);
        foreach (s[k]) put(s[k]);
    endtask

    task automatic put_number();
        put_text($sformatf("%0d", $urandom_range(0, 40)));
    endtask

    task automatic send_field(input bit sched_col);
        if (sched_col) begin
            case ($urandom_range(0, 9))
                0: ;
                1, 2, 3: begin
                    repeat ($urandom_range(0, 2)) begin
                        case ($urandom_range(0, 3))
                            0: put(csvdue_pkg::CH_SPACE);
                            1: put(csvdue_pkg::CH_TAB);
                            2: put(csvdue_pkg::CH_VT);
                            default: put(csvdue_pkg::CH_FF);
                        endcase
                    end
                    if ($urandom_range(0, 3) == 0)
                        put($urandom_range(0, 1) ? csvdue_pkg::CH_MINUS : csvdue_pkg::CH_PLUS);
                    put_number();
                end
                // long digit run: past the digit limit and wrapping
                4: repeat ($urandom_range(10, 20))
                       put(8'(csvdue_pkg::CH_ZERO + $urandom_range(0, 9)));
                5: put($urandom_range(0, 1) ? csvdue_pkg::CH_MINUS : csvdue_pkg::CH_PLUS);
                6: begin
                    put("x");
                    put_number();
                end
                7: begin
                    put(csvdue_pkg::CH_QUOTE);
                    put_number();
                    put(csvdue_pkg::CH_QUOTE);
                    if ($urandom_range(0, 1)) put(csvdue_pkg::CH_QUOTE);
                    put_number();
                end
                8: begin
                    put_number();
                    put(csvdue_pkg::CH_QUOTE);
                    put_number();
                end
                default: repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: ;
                1, 2, 3: repeat ($urandom_range(1, 3)) put(8'(8'h61 + $urandom_range(0, 25)));
                default: begin
                    // quoted field hiding delimiters, line feeds and doubled quotes
                    put(csvdue_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 3))
                            0: put(delim_cfg);
                            1: put(csvdue_pkg::CH_LF);
                            2: begin
                                put(csvdue_pkg::CH_QUOTE);
                                put(csvdue_pkg::CH_QUOTE);
                            end
                            default: put(8'(8'h61 + $urandom_range(0, 25)));
                        endcase
                    end
                    put(csvdue_pkg::CH_QUOTE);
                end
            endcase
        end
    endtask

    task automatic send_row(input int ncols, input bit term);
        for (int i = 0; i < ncols; i++) begin
            if (i != 0) put(delim_cfg);
            send_field(i == COLS - 1);
        end
        if (term) begin
            if ($urandom_range(0, 3) == 0) put(csvdue_pkg::CH_CR);
            put(csvdue_pkg::CH_LF);
        end
    endtask

    task automatic send_table();
        int ncols;
        int nrows;
        if (quiet_tail) idle_pct = 0;
        else begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
        end
        if ($urandom_range(0, 5) == 0) put(csvdue_pkg::CH_LF);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 3)) put(8'(8'h61 + $urandom_range(0, 25)));
            send_item(csvdue_pkg::OP_END, 8'($urandom_range(0, 255)));
            return;
        end
        ncols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, COLS - 1)
                                            : COLS + $urandom_range(0, 1);
        for (int i = 0; i < ncols; i++) begin
            if (i != 0) put(delim_cfg);
            put(8'(8'h41 + $urandom_range(0, 25)));
        end
        put(csvdue_pkg::CH_LF);
        nrows = $urandom_range(0, 8);
        for (int r = 0; r < nrows; r++) begin
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
                    put(csvdue_pkg::CH_LF);
                end
                1: begin
                    put(csvdue_pkg::CH_QUOTE);
                    put(csvdue_pkg::CH_QUOTE);
                    put(csvdue_pkg::CH_LF);
                end
                2: begin
                    // field index runs into saturation
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(250, 262)) put(delim_cfg);
                        put("7");
                        put(csvdue_pkg::CH_LF);
                    end
                end
                3, 4: send_row($urandom_range(1, COLS + 2), 1'b1);
                default: send_row(COLS, r != nrows - 1 || $urandom_range(0, 3) != 0);
            endcase
        end
        send_item(csvdue_pkg::OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] d, input logic [31:0] s);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= csvdue_pkg::REG_DELIMITER;
        i_cfg_data  <= {24'd0, d};
        @(posedge i_clk);
        delim_cfg    = d;
        i_cfg_index <= csvdue_pkg::REG_SESSION;
        i_cfg_data  <= s;
        @(posedge i_clk);
        session_cfg  = s;
        i_cfg_we    <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_seen;
        hold_seen = 0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_count_rec want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: counts with none expected: answer %0d due %0d rows %0d sched %0b",
                         $time, out_ch.answer_count, out_ch.due_count, out_ch.row_count,
                         out_ch.schedule_present);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                counts_checked++;
                if (out_ch.answer_count !== want.answer) begin
                    $display("%0t: answer_count expected %0d got %0d",
                             $time, want.answer, out_ch.answer_count);
                    mismatches++;
                end
                if (out_ch.due_count !== want.due) begin
                    $display("%0t: due_count expected %0d got %0d",
                             $time, want.due, out_ch.due_count);
                    mismatches++;
                end
                if (out_ch.row_count !== want.rows) begin
                    $display("%0t: row_count expected %0d got %0d",
                             $time, want.rows, out_ch.row_count);
                    mismatches++;
                end
                if (out_ch.schedule_present !== want.sched) begin
                    $display("%0t: schedule_present expected %0b got %0b",
                             $time, want.sched, out_ch.schedule_present);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int          phase_mark;
        logic [31:0] sess;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= csvdue_pkg::OP_BYTE;
        in_ch.data_byte <= 8'h00;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= csvdue_pkg::REG_DELIMITER;
        i_cfg_data      <= 32'd0;
        i_rst_n         <= 1'b0;
        items_sent     = 0;
        counts_checked = 0;
        mismatches     = 0;
        hold_token     = 0;
        quiet_tail     = 1'b0;
        idle_pct       = 15;
        delim_cfg      = csvdue_pkg::DELIM_RESET;
        session_cfg    = 32'd0;
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_steps[k])
            send_item(dir_steps[k].op, dir_steps[k].ch, dir_steps[k].typed, dir_steps[k].rec);

        for (int ph = 0; ph < NPH; ph++) begin
            drain();
            sess = (ph >= NPH - 2) ? $urandom_range(0, 40) : session_plan[ph];
            program_regs(delim_plan[ph], sess);
            if (ph == NPH - 1) quiet_tail = 1'b1;
            phase_mark = items_sent;
            if (ph == 1) begin
                // hold the output off and pile end items up behind it
                hold_token <= hold_token + 1;
                idle_pct = 0;
                repeat (4) send_item(csvdue_pkg::OP_END, 8'($urandom_range(0, 255)));
            end
            while (items_sent < phase_mark + PHASE_ITEMS) send_table();
        end
        drain();

        $display("covered %0d items and %0d tables over %0d register settings",
                 items_sent, counts_checked, NPH + 1);
        $display("quoting, signed wrapping numbers, index saturation, %0d-cycle output hold",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/csvdue_pkg.sv
rtl/csvdue_in_if.sv
rtl/csvdue_out_if.sv
rtl/csvdue_num.sv
rtl/csv_due_row_counter.sv
dv/tb_csv_due_row_counter.sv
